// ===== hw/rtl/s2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_pkg
// Shared types, character codes and helpers for the signed integer to
// right-justified decimal formatter.
// ----------------------------------------------------------------------------
package s2d_pkg;

   localparam int VALUE_W        = 16;
   localparam int LEN_W          = 4;
   localparam int CHAR_W         = 6;
   localparam int DIGIT_W        = 4;
   localparam int DEF_MAX_LEN    = 8;
   localparam int DEF_VALUE_BITS = 16;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [LEN_W-1:0]          field_length;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } rsp_type;

   // Decimal digits needed for a magnitude of up to 2^(bits-1).
   function automatic int num_digits(input int bits);
      return ((bits - 1) * 30103) / 100000 + 1;
   endfunction

   // ceil(2^(bits+3) / 10): exact floor(x/10) for any x below 2^bits.
   function automatic logic [63:0] recip10(input int bits);
      return ((64'd1 << (bits + 3)) + 64'd9) / 64'd10;
   endfunction

   // Low decimal digit of v given q = v/10; only the low bits matter (mod 16).
   function automatic logic [DIGIT_W-1:0] low_digit(input logic [DIGIT_W-1:0] v,
                                                    input logic [DIGIT_W-1:0] q);
      return v - {q[0], 3'b000} - {q[2:0], 1'b0};
   endfunction

endpackage

// ===== hw/rtl/signed_int_to_right_justified_decimal_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_right_justified_decimal_core
// Formats a signed value as a right-justified decimal ASCII field.
// ----------------------------------------------------------------------------
// Pipeline: sign stage, one divide-by-ten stage per decimal digit, field
//   build/hold, output register; the first character follows the input
//   transfer through these registers in that order.
// Output: one character per cycle while rsp_ready does not stall the result
//   channel; a new item is taken while the previous field drains.
// Reset: synchronous, clears valid bits only; no state survives an item.
module signed_int_to_right_justified_decimal_core
   import s2d_pkg::*;
#(
   parameter int MAX_LEN    = DEF_MAX_LEN,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int NUM_DIG  = num_digits(VALUE_BITS);
   localparam int ND_BITS  = $clog2(NUM_DIG + 1);
   localparam int LEN_BITS = $clog2(MAX_LEN + 1);

   logic [VALUE_BITS+VALUE_W-1:0] ext_value;
   logic [VALUE_BITS-1:0]         raw;
   logic                          neg_in;
   logic [VALUE_BITS-1:0]         mag_in;
   logic [LEN_BITS-1:0]           len_in;
   logic                          prep_valid_ff;
   logic                          prep_neg_ff;
   logic [VALUE_BITS-1:0]         prep_mag_ff;
   logic [LEN_BITS-1:0]           prep_len_ff;

   logic                            st_valid  [0:NUM_DIG];
   logic                            st_ready  [0:NUM_DIG];
   logic [VALUE_BITS-1:0]           st_mag    [0:NUM_DIG];
   logic [VALUE_BITS-1:0]           st_prev   [0:NUM_DIG];
   logic [NUM_DIG-1:0][DIGIT_W-1:0] st_digits [0:NUM_DIG];
   logic [ND_BITS-1:0]              st_nd     [0:NUM_DIG];
   logic                            st_neg    [0:NUM_DIG];
   logic [LEN_BITS-1:0]             st_len    [0:NUM_DIG];

   // Sign and magnitude; two's complement negate gives 2^(VALUE_BITS-1)
   // for the most negative value, which fits unsigned.
   always_comb begin
      ext_value = {{VALUE_BITS{req_payload.value[VALUE_W-1]}}, req_payload.value};
      raw       = ext_value[VALUE_BITS-1:0];
      neg_in    = raw[VALUE_BITS-1];
      mag_in    = neg_in ? (~raw + 1'b1) : raw;
      if (req_payload.field_length == '0) begin
         len_in = LEN_BITS'(1);
      end else if (int'(req_payload.field_length) > MAX_LEN) begin
         len_in = LEN_BITS'(MAX_LEN);
      end else begin
         len_in = LEN_BITS'(req_payload.field_length);
      end
   end

   assign req_ready = !prep_valid_ff || st_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (req_ready) begin
         prep_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         prep_neg_ff <= neg_in;
         prep_mag_ff <= mag_in;
         prep_len_ff <= len_in;
      end
   end

   assign st_valid[0]  = prep_valid_ff;
   assign st_mag[0]    = prep_mag_ff;
   assign st_prev[0]   = '0;
   assign st_digits[0] = '0;
   assign st_nd[0]     = '0;
   assign st_neg[0]    = prep_neg_ff;
   assign st_len[0]    = prep_len_ff;

   for (genvar k = 0; k < NUM_DIG; k++) begin : g_digit
      s2d_digit_stage #(
         .IDX        (k),
         .VALUE_BITS (VALUE_BITS),
         .NUM_DIG    (NUM_DIG),
         .LEN_BITS   (LEN_BITS),
         .ND_BITS    (ND_BITS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .up_valid  (st_valid[k]),
         .up_ready  (st_ready[k]),
         .up_mag    (st_mag[k]),
         .up_prev   (st_prev[k]),
         .up_digits (st_digits[k]),
         .up_nd     (st_nd[k]),
         .up_neg    (st_neg[k]),
         .up_len    (st_len[k]),
         .dn_valid  (st_valid[k+1]),
         .dn_ready  (st_ready[k+1]),
         .dn_mag    (st_mag[k+1]),
         .dn_prev   (st_prev[k+1]),
         .dn_digits (st_digits[k+1]),
         .dn_nd     (st_nd[k+1]),
         .dn_neg    (st_neg[k+1]),
         .dn_len    (st_len[k+1])
      );
   end

   s2d_serializer #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIG    (NUM_DIG),
      .MAX_LEN    (MAX_LEN),
      .LEN_BITS   (LEN_BITS),
      .ND_BITS    (ND_BITS)
   ) u_serializer (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (st_valid[NUM_DIG]),
      .up_ready    (st_ready[NUM_DIG]),
      .up_mag      (st_mag[NUM_DIG]),
      .up_prev     (st_prev[NUM_DIG]),
      .up_digits   (st_digits[NUM_DIG]),
      .up_nd       (st_nd[NUM_DIG]),
      .up_neg      (st_neg[NUM_DIG]),
      .up_len      (st_len[NUM_DIG]),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hw/rtl/s2d_digit_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_digit_stage
// One pipeline stage of the decimal conversion: divides the running magnitude
// by ten and resolves the digit of the previous stage from its quotient.
// ----------------------------------------------------------------------------
module s2d_digit_stage
   import s2d_pkg::*;
#(
   parameter int IDX        = 0,
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   parameter int NUM_DIG    = 5,
   parameter int LEN_BITS   = 4,
   parameter int ND_BITS    = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  logic [VALUE_BITS-1:0]             up_mag,
   input  logic [VALUE_BITS-1:0]             up_prev,
   input  logic [NUM_DIG-1:0][DIGIT_W-1:0]   up_digits,
   input  logic [ND_BITS-1:0]                up_nd,
   input  logic                              up_neg,
   input  logic [LEN_BITS-1:0]               up_len,
   output logic                              dn_valid,
   input  logic                              dn_ready,
   output logic [VALUE_BITS-1:0]             dn_mag,
   output logic [VALUE_BITS-1:0]             dn_prev,
   output logic [NUM_DIG-1:0][DIGIT_W-1:0]   dn_digits,
   output logic [ND_BITS-1:0]                dn_nd,
   output logic                              dn_neg,
   output logic [LEN_BITS-1:0]               dn_len
);

   localparam int SHIFT = VALUE_BITS + 3;
   localparam logic [VALUE_BITS-1:0] RECIP = VALUE_BITS'(recip10(VALUE_BITS));
   localparam int DSLOT = (IDX > 0) ? IDX - 1 : 0;

   logic                            valid_ff;
   logic [VALUE_BITS-1:0]           mag_ff, mag_in;
   logic [VALUE_BITS-1:0]           prev_ff;
   logic [NUM_DIG-1:0][DIGIT_W-1:0] digits_ff, digits_in;
   logic [ND_BITS-1:0]              nd_ff, nd_in;
   logic                            neg_ff;
   logic [LEN_BITS-1:0]             len_ff;
   logic [2*VALUE_BITS-1:0]         prod;
   logic                            advance;

   assign up_ready = !valid_ff || dn_ready;
   assign advance  = up_valid && up_ready;

   always_comb begin
      prod   = {{VALUE_BITS{1'b0}}, up_mag} * {{VALUE_BITS{1'b0}}, RECIP};
      mag_in = VALUE_BITS'(prod >> SHIFT);
      digits_in = up_digits;
      // previous stage's digit is known once its quotient is here
      if (IDX > 0) begin
         digits_in[DSLOT] = low_digit(up_prev[DIGIT_W-1:0], up_mag[DIGIT_W-1:0]);
      end
      if (IDX == 0 || up_mag != '0) begin
         nd_in = ND_BITS'(IDX + 1);
      end else begin
         nd_in = up_nd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (advance) begin
         mag_ff    <= mag_in;
         prev_ff   <= up_mag;
         digits_ff <= digits_in;
         nd_ff     <= nd_in;
         neg_ff    <= up_neg;
         len_ff    <= up_len;
      end
   end

   assign dn_valid  = valid_ff;
   assign dn_mag    = mag_ff;
   assign dn_prev   = prev_ff;
   assign dn_digits = digits_ff;
   assign dn_nd     = nd_ff;
   assign dn_neg    = neg_ff;
   assign dn_len    = len_ff;

endmodule

// ===== hw/rtl/s2d_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_serializer
// Builds the character field of one item and emits it one character per
// transfer, rightmost character flagged, through a registered output.
// ----------------------------------------------------------------------------
module s2d_serializer
   import s2d_pkg::*;
#(
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   parameter int NUM_DIG    = 5,
   parameter int MAX_LEN    = DEF_MAX_LEN,
   parameter int LEN_BITS   = 4,
   parameter int ND_BITS    = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            up_valid,
   output logic                            up_ready,
   input  logic [VALUE_BITS-1:0]           up_mag,
   input  logic [VALUE_BITS-1:0]           up_prev,
   input  logic [NUM_DIG-1:0][DIGIT_W-1:0] up_digits,
   input  logic [ND_BITS-1:0]              up_nd,
   input  logic                            up_neg,
   input  logic [LEN_BITS-1:0]             up_len,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rsp_type                         rsp_payload
);

   localparam int DARR     = (NUM_DIG > MAX_LEN) ? NUM_DIG : MAX_LEN;
   localparam int CNT_BITS = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic [DARR-1:0][DIGIT_W-1:0]    dpad;
   logic [MAX_LEN-1:0][CHAR_W-1:0]  chars_built;
   logic [MAX_LEN-1:0][CHAR_W-1:0]  chars_ff, chars_in;
   logic [CNT_BITS-1:0]             rcnt_ff, rcnt_in;
   logic                            hold_valid_ff, hold_valid_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rsp_type                         rsp_ff, rsp_in;
   logic                            out_load;
   logic                            last_now;
   logic                            up_take;

   // Characters indexed from the right: slot 0 is the last one emitted.
   always_comb begin
      dpad = '0;
      for (int i = 0; i < NUM_DIG; i++) begin
         dpad[i] = up_digits[i];
      end
      dpad[NUM_DIG-1] = low_digit(up_prev[DIGIT_W-1:0], up_mag[DIGIT_W-1:0]);
      for (int p = 0; p < MAX_LEN; p++) begin
         if (p < int'(up_nd)) begin
            chars_built[p] = CH_ZERO + CHAR_W'(dpad[p]);
         end else if (p == int'(up_nd) && up_neg) begin
            chars_built[p] = CH_MINUS;
         end else begin
            chars_built[p] = CH_SPACE;
         end
      end
   end

   assign out_load = !rsp_valid_ff || rsp_ready;
   assign last_now = hold_valid_ff && (rcnt_ff == '0);
   assign up_ready = !hold_valid_ff || (out_load && last_now);
   assign up_take  = up_valid && up_ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      chars_in      = chars_ff;
      rcnt_in       = rcnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      if (out_load) begin
         rsp_valid_in = hold_valid_ff;
         if (hold_valid_ff) begin
            rsp_in.char_code = chars_ff[rcnt_ff];
            rsp_in.last_char = last_now;
            if (last_now) begin
               hold_valid_in = 1'b0;
            end else begin
               rcnt_in = rcnt_ff - 1'b1;
            end
         end
      end
      if (up_take) begin
         hold_valid_in = 1'b1;
         chars_in      = chars_built;
         rcnt_in       = CNT_BITS'(up_len - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      chars_ff <= chars_in;
      rcnt_ff  <= rcnt_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // a character other than the last leaves the rest of its field in hold
   a_mid_field_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last_char |-> hold_valid_ff)
      else $error("field characters missing behind a non-last character");

   // no gap inside a field once a non-last character is transferred
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !rsp_ff.last_char |=> rsp_valid_ff)
      else $error("gap inside a field");

   // a stalled output keeps the remaining characters in place
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && !out_load |=> hold_valid_ff && $stable(rcnt_ff) && $stable(chars_ff))
      else $error("held field changed during stall");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the right-justified decimal formatter. Requests
// are sent in directed groups (value and length extremes, saturation of the
// field length, digits overflowing the field, zero), then in random traffic
// under three stall profiles. Every character transfer is checked against a
// queue of characters predicted when its request is accepted.
// ----------------------------------------------------------------------------
module tb_top;
   import s2d_pkg::*;

   localparam int CLK_HALF    = 5;
   localparam int FIELD_MAX   = 8;
   localparam int DRAIN_WAIT  = 20;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REQ_W       = $bits(req_type);

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   rsp_type expected_chars[$];
   int      mismatch_count;
   int      cycle_count;
   int      send_idle_pct;
   int      recv_stall_pct;

   signed_int_to_right_justified_decimal_core #(
      .MAX_LEN    (FIELD_MAX),
      .VALUE_BITS (VALUE_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1;
      #CLK_HALF;
      clock = 1'b0;
      #CLK_HALF;
   end

   // Builds the field text for one request and queues its characters.
   function automatic void format_field(input req_type r);
      logic [CHAR_W-1:0] text [FIELD_MAX];
      logic              neg;
      int unsigned       mag;
      int                len;
      int                pos;
      neg = r.value[VALUE_W-1];
      mag = neg ? (32'd1 << VALUE_W) - {16'd0, r.value} : {16'd0, r.value};
      len = int'(r.field_length);
      if (len < 1)
         len = 1;
      if (len > FIELD_MAX)
         len = FIELD_MAX;
      pos = len - 1;
      do begin
         text[pos] = CH_ZERO + CHAR_W'(mag % 10);
         pos--;
         mag = mag / 10;
      end while (mag != 0 && pos >= 0);
      if (neg && pos >= 0) begin
         text[pos] = CH_MINUS;
         pos--;
      end
      while (pos >= 0) begin
         text[pos] = CH_SPACE;
         pos--;
      end
      for (int i = 0; i < len; i++)
         expected_chars.push_back('{char_code: text[i], last_char: (i == len - 1)});
   endfunction

   // One request transfer, with a random gap in front of it.
   task automatic send_number(input logic signed [VALUE_W-1:0] value,
                              input logic [LEN_W-1:0] field_length);
      req_type r;
      r.value        = value;
      r.field_length = field_length;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid   <= 1'b0;
         req_payload <= req_type'(REQ_W'($urandom));
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      format_field(r);
   endtask

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character, actual %0d last %0b",
                     $time, rsp_payload.char_code, rsp_payload.last_char);
            mismatch_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_payload.char_code !== want.char_code) begin
               $display("%0t: char_code expected %0d actual %0d",
                        $time, want.char_code, rsp_payload.char_code);
               mismatch_count++;
            end
            if (rsp_payload.last_char !== want.last_char) begin
               $display("%0t: last_char expected %0b actual %0b",
                        $time, want.last_char, rsp_payload.last_char);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic test_value_extremes();
      send_number(-16'sd32768, 4'd8);
      send_number(16'sd32767, 4'd8);
      send_number(16'sd0, 4'd8);
      send_number(-16'sd1, 4'd8);
      send_number(16'sd1, 4'd8);
      send_number(16'sd0, 4'd1);
      send_number(16'sd0, 4'd4);
      send_number(-16'sd32768, 4'd1);
      send_number(16'sd32767, 4'd1);
   endtask

   // Lengths of zero and above the maximum saturate.
   task automatic test_length_saturation();
      send_number(16'sd7, 4'd0);
      send_number(-16'sd9, 4'd0);
      send_number(-16'sd4321, 4'd9);
      send_number(16'sd21845, 4'd15);
      send_number(-16'sd10922, 4'd10);
   endtask

   // Leading digits, and then the sign, fall off the left of the field.
   task automatic test_digit_overflow();
      send_number(-16'sd32768, 4'd6);
      send_number(-16'sd32768, 4'd5);
      send_number(-16'sd32768, 4'd3);
      send_number(16'sd12345, 4'd3);
      send_number(-16'sd12345, 4'd5);
      send_number(-16'sd5, 4'd1);
      send_number(-16'sd5, 4'd2);
      send_number(16'sd10000, 4'd4);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int v;
      case ($urandom_range(3))
         0: v = int'($signed(16'($urandom)));
         1: v = $urandom_range(200);
         2: begin
            v = 1;
            repeat ($urandom_range(4)) v = v * 10;
            v = v + $urandom_range(2) - 1;
         end
         default: v = $urandom_range(1) ? 32767 : -32768;
      endcase
      if ($urandom_range(1) && v > 0 && v < 32768)
         v = -v;
      return VALUE_W'(v);
   endfunction

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int n_items);
      logic [LEN_W-1:0] len;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (n_items) begin
         if ($urandom_range(99) < 85)
            len = LEN_W'($urandom_range(FIELD_MAX, 1));
         else
            len = LEN_W'($urandom_range(15));
         send_number(pick_value(), len);
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      rsp_ready      = 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;
      send_idle_pct  = 6;
      recv_stall_pct = 46;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_value_extremes();
      test_length_saturation();
      test_digit_overflow();
      test_random_traffic(6, 46, 140);
      test_random_traffic(46, 6, 140);
      test_random_traffic(0, 0, 140);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
